FILE: sv/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    // one below 'A', so 'A' maps to drive 1
    localparam logic [7:0] DRIVE_BASE = 8'h40;

    localparam logic [63:0] SPACES_NAME = 64'h2020_2020_2020_2020;
    localparam logic [23:0] SPACES_EXT  = 24'h20_2020;

    localparam logic [3:0] NAME_LEN = 4'd8;
    localparam logic [3:0] EXT_LEN  = 4'd3;

endpackage

`default_nettype wire

FILE: sv/cpm_filename_to_fcb_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// the result is registered into the output stage when the transaction that carries the last byte is taken
// throughput: one byte per cycle while s_ready is high (it drops while the skid entry is full); the parse state
// updates as each byte is taken; a two-entry output stage lets bytes keep flowing while a finished result waits
// reset (aresetn low, synchronous) clears the parse state, default_user and the output stage

module cpm_filename_to_fcb_parser_top
    import cfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_drive,
    output logic [7:0]       m_user,
    output logic [63:0]      m_name_chars,
    output logic [23:0]      m_ext_chars
);

    typedef enum logic [2:0] {
        PH_HEAD, PH_UD0, PH_UD1, PH_NAME, PH_SKIP, PH_EXT, PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  hb0;
        logic [7:0]  drive;
        logic [7:0]  user;
        logic        user_seen;
        logic [63:0] name;
        logic [23:0] ext;
        logic [3:0]  fill;
    } pst_t;

    typedef struct packed {
        logic [7:0]  drive;
        logic [7:0]  user;
        logic [63:0] name;
        logic [23:0] ext;
    } res_t;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DIFF : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic pst_t name_feed(input pst_t s, input logic [7:0] c);
        pst_t r;
        r = s;
        unique case (s.phase)
            PH_NAME: begin
                if (c == CH_DOT || c == CH_STAR || c <= CH_SPACE || s.fill >= NAME_LEN) begin
                    if (c == CH_STAR) begin
                        for (int i = 0; i < 8; i++) begin
                            if (4'(i) >= s.fill) r.name[(7 - i) * 8 +: 8] = CH_QMARK;
                        end
                    end
                    r.fill  = 4'd0;
                    r.phase = (c == CH_DOT) ? PH_EXT : PH_SKIP;
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        if (s.fill[2:0] == 3'(i)) r.name[(7 - i) * 8 +: 8] = up_case(c);
                    end
                    r.fill = s.fill + 4'd1;
                end
            end
            PH_SKIP: begin
                if (c == CH_DOT) r.phase = PH_EXT;
            end
            PH_EXT: begin
                if (c <= CH_SPACE || c == CH_STAR || s.fill >= EXT_LEN) begin
                    if (c == CH_STAR) begin
                        for (int i = 0; i < 3; i++) begin
                            if (4'(i) >= s.fill) r.ext[(2 - i) * 8 +: 8] = CH_QMARK;
                        end
                    end
                    r.phase = PH_DONE;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (s.fill == 4'(i)) r.ext[(2 - i) * 8 +: 8] = up_case(c);
                    end
                    r.fill = s.fill + 4'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic pst_t body_feed(input pst_t s, input logic [7:0] c);
        pst_t r;
        r = s;
        unique case (s.phase)
            PH_UD0: begin
                if (is_digit(c)) begin
                    r.phase = PH_NAME;
                    r = name_feed(r, c);
                end else begin
                    r.hb0   = c;
                    r.phase = PH_UD1;
                end
            end
            PH_UD1: begin
                r.phase = PH_NAME;
                if (c == CH_COLON) begin
                    r.drive = up_case(s.hb0) - DRIVE_BASE;
                end else begin
                    r = name_feed(r, s.hb0);
                    r = name_feed(r, c);
                end
            end
            default: r = name_feed(s, c);
        endcase
        return r;
    endfunction

    // resolve the held-back head: optional user/drive prefix, then feed the rest
    function automatic pst_t process_head(input pst_t s, input logic [3:0][7:0] h,
                                          input logic [2:0] len);
        pst_t       r;
        logic       colon;
        logic       stop;
        logic [2:0] start;
        r     = s;
        colon = 1'b0;
        stop  = 1'b0;
        start = 3'd0;
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < len && h[i] == CH_COLON) colon = 1'b1;
        end
        if (colon) begin
            for (int p = 0; p < 4; p++) begin
                if (!stop) begin
                    if (3'(p) < len && h[p] != CH_COLON) begin
                        if (is_digit(h[p])) begin
                            r.user = (r.user << 3) + (r.user << 1) + (h[p] - CH_ZERO);
                            r.user_seen = 1'b1;
                        end else if (r.drive == 8'd0) begin
                            r.drive = up_case(h[p]) - DRIVE_BASE;
                        end
                    end else begin
                        stop  = 1'b1;
                        start = 3'(p) + 3'd1;
                    end
                end
            end
        end
        r.phase = (r.drive == 8'd0) ? PH_UD0 : PH_NAME;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) >= start && 3'(i) < len) r = body_feed(r, h[i]);
        end
        return r;
    endfunction

    // end of name: a pending single prefix letter becomes a name byte
    function automatic pst_t finish(input pst_t s);
        pst_t r;
        r = s;
        if (s.phase == PH_UD1) begin
            r.phase = PH_NAME;
            r = name_feed(r, s.hb0);
        end
        r.phase = PH_DONE;
        return r;
    endfunction

    pst_t             st_reg, st_next, st_work;
    logic [3:0][7:0]  head_buf_reg, head_buf_next, hb_work;
    logic [2:0]       head_count_reg, head_count_next, cnt_work;
    logic [3:0]       default_user_reg;
    res_t             main_reg, skid_reg, res_new;
    logic             main_valid_reg, skid_valid_reg;
    logic             push, pop;
    logic             is_term;

    assign s_ready = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_drive      = main_reg.drive;
    assign m_user       = main_reg.user;
    assign m_name_chars = main_reg.name;
    assign m_ext_chars  = main_reg.ext;

    assign push = s_valid && s_ready && s_last;
    assign pop  = main_valid_reg && m_ready;

    always_comb begin
        st_work  = st_reg;
        hb_work  = head_buf_reg;
        cnt_work = head_count_reg;
        is_term  = (s_ch == 8'd0) || s_ch[7];
        if (st_reg.phase != PH_DONE) begin
            if (st_reg.phase == PH_HEAD) begin
                if (is_term) begin
                    st_work = finish(process_head(st_work, hb_work, cnt_work));
                end else begin
                    hb_work[cnt_work[1:0]] = s_ch;
                    cnt_work = cnt_work + 3'd1;
                    st_work.hb0 = hb_work[0];
                    if (cnt_work == 3'd4 || s_last)
                        st_work = process_head(st_work, hb_work, cnt_work);
                end
            end else if (is_term) begin
                st_work = finish(st_work);
            end else begin
                st_work = body_feed(st_work, s_ch);
            end
        end
        if (s_last && st_work.phase != PH_DONE) st_work = finish(st_work);
        hb_work[0] = st_work.hb0;

        res_new.drive = st_work.drive;
        res_new.user  = st_work.user_seen ? st_work.user : {4'd0, default_user_reg};
        res_new.name  = st_work.name;
        res_new.ext   = st_work.ext;

        st_next         = st_reg;
        head_buf_next   = head_buf_reg;
        head_count_next = head_count_reg;
        if (s_valid && s_ready) begin
            if (s_last) begin
                st_next         = '{phase: PH_HEAD, hb0: 8'd0, drive: 8'd0, user: 8'd0,
                                    user_seen: 1'b0, name: SPACES_NAME, ext: SPACES_EXT,
                                    fill: 4'd0};
                head_buf_next   = '0;
                head_count_next = 3'd0;
            end else begin
                st_next         = st_work;
                head_buf_next   = hb_work;
                head_count_next = cnt_work;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg           <= '{phase: PH_HEAD, hb0: 8'd0, drive: 8'd0, user: 8'd0,
                                  user_seen: 1'b0, name: SPACES_NAME, ext: SPACES_EXT,
                                  fill: 4'd0};
            head_buf_reg     <= '0;
            head_count_reg   <= 3'd0;
            default_user_reg <= 4'd0;
            main_valid_reg   <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            st_reg         <= st_next;
            head_buf_reg   <= head_buf_next;
            head_count_reg <= head_count_next;
            if (cfg_we) default_user_reg <= cfg_wdata;
            // two-entry output stage: main feeds the port, skid catches a result on stall
            if (!main_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : res_new;
        end else if (push) begin
            skid_reg <= res_new;
        end
    end

endmodule

`default_nettype wire

FILE: sim/cpm_filename_to_fcb_parser_top_tb.sv
`timescale 1ns / 1ps

import cfp_pkg::*;

typedef logic [7:0] char_t;

typedef struct packed {
    logic [7:0]  drive;
    logic [7:0]  user;
    logic [63:0] name_chars;
    logic [23:0] ext_chars;
} fcb_t;

typedef enum logic [2:0] {
    SCAN_HEAD,
    SCAN_USER_DRIVE,
    SCAN_DRIVE_COLON,
    SCAN_NAME,
    SCAN_SKIP,
    SCAN_EXT,
    SCAN_DONE
} scan_phase_t;

class fcb_parse_checker;
    fcb_t        pending_fcbs[$];
    logic [3:0]  default_user;
    int          mismatches;
    int          fcbs_checked;

    char_t       head_buf[4];
    logic [2:0]  head_cnt;
    scan_phase_t phase;
    logic [7:0]  drive_v;
    logic [7:0]  user_v;
    logic        user_seen;
    logic [63:0] name_v;
    logic [23:0] ext_v;
    logic [3:0]  fill;

    function new();
        default_user = 4'd0;
        mismatches = 0;
        fcbs_checked = 0;
        clear();
    endfunction

    function void clear();
        foreach (head_buf[i]) head_buf[i] = 8'h00;
        head_cnt = 3'd0;
        phase = SCAN_HEAD;
        drive_v = 8'd0;
        user_v = 8'd0;
        user_seen = 1'b0;
        name_v = SPACES_NAME;
        ext_v = SPACES_EXT;
        fill = 4'd0;
    endfunction

    function char_t upcase(char_t c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? char_t'(c - CASE_DIFF) : c;
    endfunction

    function bit is_digit(char_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // any non-digit counts as a drive letter, wrapping modulo 256
    function char_t drive_of(char_t c);
        return char_t'(upcase(c) - DRIVE_BASE);
    endfunction

    function void put_name(int i, char_t v);
        name_v[(7 - (i % 8)) * 8 +: 8] = v;
    endfunction

    function void put_ext(int i, char_t v);
        ext_v[(2 - (i % 3)) * 8 +: 8] = v;
    endfunction

    function void name_feed(char_t c);
        int i;
        case (phase)
            SCAN_NAME: begin
                if (c == CH_DOT || c == CH_STAR || c <= CH_SPACE || fill >= NAME_LEN) begin
                    if (c == CH_STAR)
                        for (i = fill; i < NAME_LEN; i++) put_name(i, CH_QMARK);
                    fill = 4'd0;
                    phase = (c == CH_DOT) ? SCAN_EXT : SCAN_SKIP;
                end else begin
                    put_name(fill, upcase(c));
                    fill++;
                end
            end
            SCAN_SKIP: begin
                if (c == CH_DOT) phase = SCAN_EXT;
            end
            SCAN_EXT: begin
                if (c <= CH_SPACE || c == CH_STAR || fill >= EXT_LEN) begin
                    if (c == CH_STAR)
                        for (i = fill; i < EXT_LEN; i++) put_ext(i, CH_QMARK);
                    phase = SCAN_DONE;
                end else begin
                    put_ext(fill, upcase(c));
                    fill++;
                end
            end
            default: ;
        endcase
    endfunction

    function void body_feed(char_t c);
        case (phase)
            SCAN_USER_DRIVE: begin
                if (is_digit(c)) begin
                    phase = SCAN_NAME;
                    name_feed(c);
                end else begin
                    head_buf[0] = c;
                    phase = SCAN_DRIVE_COLON;
                end
            end
            SCAN_DRIVE_COLON: begin
                phase = SCAN_NAME;
                if (c == CH_COLON) begin
                    drive_v = drive_of(head_buf[0]);
                end else begin
                    name_feed(head_buf[0]);
                    name_feed(c);
                end
            end
            default: name_feed(c);
        endcase
    endfunction

    // look for a colon at positions 1..3 and split off the user/drive prefix
    function void scan_head(int len);
        char_t h[4];
        int    i;
        int    p;
        int    start;
        bit    colon;
        h = head_buf;
        p = 0;
        start = 0;
        colon = 1'b0;
        if (len > 4) len = 4;
        for (i = 1; i < 4; i++)
            if (i < len && h[i] == CH_COLON) colon = 1'b1;
        if (colon) begin
            while (p < len && h[p] != CH_COLON) begin
                if (is_digit(h[p])) begin
                    user_v = user_v * 8'd10 + (h[p] - CH_ZERO);
                    user_seen = 1'b1;
                end else if (drive_v == 8'd0) begin
                    drive_v = drive_of(h[p]);
                end
                p++;
            end
            start = p + 1;
        end
        phase = (drive_v == 8'd0) ? SCAN_USER_DRIVE : SCAN_NAME;
        for (i = start; i < len; i++) body_feed(h[i]);
    endfunction

    function void close_name();
        if (phase == SCAN_HEAD) scan_head(head_cnt);
        if (phase == SCAN_DRIVE_COLON) begin
            phase = SCAN_NAME;
            name_feed(head_buf[0]);
        end
        phase = SCAN_DONE;
    endfunction

    function void take_byte(char_t c, bit last);
        fcb_t fcb;
        if (phase != SCAN_DONE) begin
            if (c == 8'h00 || c[7]) begin
                close_name();
            end else if (phase == SCAN_HEAD) begin
                head_buf[head_cnt[1:0]] = c;
                head_cnt++;
                if (head_cnt >= 3'd4) scan_head(4);
            end else begin
                body_feed(c);
            end
        end
        if (last) begin
            if (phase != SCAN_DONE) close_name();
            fcb.drive = drive_v;
            fcb.user = user_seen ? user_v : {4'd0, default_user};
            fcb.name_chars = name_v;
            fcb.ext_chars = ext_v;
            pending_fcbs.push_back(fcb);
            clear();
        end
    endfunction

    function void check_fcb(fcb_t got);
        fcb_t want;
        if (pending_fcbs.size() == 0) begin
            $error("unexpected result: drive %h user %h name %h ext %h",
                   got.drive, got.user, got.name_chars, got.ext_chars);
            mismatches++;
            return;
        end
        want = pending_fcbs.pop_front();
        fcbs_checked++;
        if (got.drive !== want.drive) begin
            $error("drive: expected %h, got %h", want.drive, got.drive);
            mismatches++;
        end
        if (got.user !== want.user) begin
            $error("user: expected %h, got %h", want.user, got.user);
            mismatches++;
        end
        if (got.name_chars !== want.name_chars) begin
            $error("name_chars: expected %h, got %h", want.name_chars, got.name_chars);
            mismatches++;
        end
        if (got.ext_chars !== want.ext_chars) begin
            $error("ext_chars: expected %h, got %h", want.ext_chars, got.ext_chars);
            mismatches++;
        end
    endfunction
endclass

module cpm_filename_to_fcb_parser_top_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_ch = 8'd0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_drive;
    logic [7:0]  m_user;
    logic [63:0] m_name_chars;
    logic [23:0] m_ext_chars;

    fcb_parse_checker fcb_check;
    int burst_left = 0;
    int names_sent = 0;
    int bytes_sent = 0;
    int user_writes = 0;
    bit hold_off_req = 1'b0;

    cpm_filename_to_fcb_parser_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_user       (m_user),
        .m_name_chars (m_name_chars),
        .m_ext_chars  (m_ext_chars)
    );

    always #4 aclk = ~aclk;

    task automatic send_byte(char_t c, bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_ch <= c;
        s_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fcb_check.take_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_name(char_t q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
        names_sent++;
    endtask

    task automatic send_text(string s);
        char_t q[$];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_name(q);
    endtask

    // stop offering and let every pending result come out
    task automatic drain();
        s_valid <= 1'b0;
        while (fcb_check.pending_fcbs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_default_user(logic [3:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        fcb_check.default_user = v;
        user_writes++;
    endtask

    function automatic char_t pick_letter();
        return char_t'($urandom_range(0, 25))
               + ($urandom_range(0, 1) ? CH_LOWER_A : char_t'(CH_LOWER_A - CASE_DIFF));
    endfunction

    function automatic char_t pick_char();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return pick_letter();
            5:  return char_t'(CH_ZERO + $urandom_range(0, 9));
            6:  return CH_STAR;
            7:  return CH_DOT;
            8:  return CH_COLON;
            9:  return CH_QMARK;
            10: return char_t'($urandom_range(1, 32));
            default: return char_t'($urandom_range(1, 127));
        endcase
    endfunction

    // mostly well-formed [user][drive]:[d:]name[.ext] with random content
    task automatic make_name(output char_t q[$]);
        int n;
        q = {};
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) q.push_back(char_t'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(0, 3);
            repeat (n) q.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
            if (n == 0 || $urandom_range(0, 1)) q.push_back(pick_letter());
            q.push_back(CH_COLON);
        end
        if ($urandom_range(0, 3) == 0) begin
            q.push_back(pick_letter());
            q.push_back(CH_COLON);
        end
        n = $urandom_range(0, 10);
        repeat (n) q.push_back(pick_char());
        if ($urandom_range(0, 1)) begin
            q.push_back(CH_DOT);
            n = $urandom_range(0, 4);
            repeat (n) q.push_back(pick_char());
        end
        // early terminator followed by bytes that must be ignored
        if ($urandom_range(0, 5) == 0) begin
            q.push_back($urandom_range(0, 1) ? 8'h00 : char_t'($urandom_range(128, 255)));
            n = $urandom_range(0, 3);
            repeat (n) q.push_back(char_t'($urandom_range(0, 255)));
        end
        if (q.size() == 0) q.push_back(pick_char());
    endtask

    // receiver: stall mode is re-picked at random from time to time, plus one long hold-off on request
    initial begin
        int cyc;
        int mode;
        int hold_left;
        cyc = 0;
        mode = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (cyc % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            fcb_check.check_fcb({m_drive, m_user, m_name_chars, m_ext_chars});
    end

    initial begin
        #(2_000_000);
        $error("timeout with %0d results outstanding", fcb_check.pending_fcbs.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        char_t q[$];
        int    target;
        int    waited;
        fcb_check = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_default_user(4'd15);
        // lower-case drive, wildcards in name and extension
        send_text("a:x*.c*");
        // three-digit user wraps, then the u:d: form
        send_text("999:b:q");
        // colon at position zero gives an empty prefix
        send_text(":1:");
        q = {8'hFF};
        send_name(q);
        // zero byte ends the name, the rest is ignored
        q = {8'h6B, 8'h00, 8'h7A, 8'h7A};
        send_name(q);
        // non-letter drive that maps to zero
        send_text("@:");

        for (int ph = 0; ph < 5; ph++) begin
            write_default_user(ph == 0 ? 4'd0 : ph == 1 ? 4'd15 : 4'($urandom_range(0, 15)));
            if (ph == 2) hold_off_req = 1'b1;
            target = bytes_sent + 150;
            while (bytes_sent < target) begin
                make_name(q);
                send_name(q);
            end
        end

        s_valid <= 1'b0;
        waited = 0;
        while (fcb_check.pending_fcbs.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (fcb_check.pending_fcbs.size() != 0) begin
            $error("%0d results never arrived", fcb_check.pending_fcbs.size());
            fcb_check.mismatches++;
        end

        $display("sent %0d names in %0d bytes under %0d default-user settings",
                 names_sent, bytes_sent, user_writes);
        $display("checked %0d parsed results with random gaps, stalls and a long hold-off",
                 fcb_check.fcbs_checked);
        if (fcb_check.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
